### src/triangle_height_at_xz_unit_defines.svh
// Assertion macros shared by the triangle height block.
`ifndef TRIANGLE_HEIGHT_AT_XZ_UNIT_DEFINES_SVH
`define TRIANGLE_HEIGHT_AT_XZ_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define THXZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define THXZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/thxz_pkg.sv
// Widths and sideband type shared by the triangle height pipeline.
package thxz_pkg;
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DET_W   = PROD_W + 1;
  localparam int NUM_W   = DET_W + DIFF_W + 1;
  localparam int QUO_W   = 34;
  localparam int DEN_W   = DET_W;

  typedef struct packed {
    logic [COORD_W-1:0] a_y;
    logic               neg;
    logic               ovf;
    logic               hit;
  } side_t;
endpackage

### src/thxz_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module thxz_div import thxz_pkg::*; #(
  parameter int DEN_BITS = DEN_W,
  parameter int QUO_BITS = QUO_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [DEN_BITS-1:0] in_rem,
  input  logic [DEN_BITS-1:0] in_den,
  input  logic [QUO_BITS-1:0] in_low,
  input  side_t               in_side,
  output logic                out_valid,
  output logic [QUO_BITS-1:0] out_quo,
  output side_t               out_side
);
  logic [QUO_BITS:0]   v_r;
  logic [DEN_BITS-1:0] rem_r [0:QUO_BITS];
  logic [DEN_BITS-1:0] den_r [0:QUO_BITS];
  logic [QUO_BITS-1:0] low_r [0:QUO_BITS];
  logic [QUO_BITS-1:0] quo_r [0:QUO_BITS];
  side_t               side_r [0:QUO_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_rem;
      den_r[0]  <= in_den;
      low_r[0]  <= in_low;
      quo_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;
    logic                ge;
    logic [DEN_BITS-1:0] rem_nxt;

    // Bring down the next numerator bit and try the subtraction.
    assign shifted = {rem_r[k], low_r[k][QUO_BITS-1]};
    assign diff    = shifted - {1'b0, den_r[k]};
    assign ge      = shifted >= {1'b0, den_r[k]};
    assign rem_nxt = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        den_r[k+1]  <= den_r[k];
        low_r[k+1]  <= {low_r[k][QUO_BITS-2:0], 1'b0};
        quo_r[k+1]  <= {quo_r[k][QUO_BITS-2:0], ge};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[QUO_BITS];
  assign out_quo   = quo_r[QUO_BITS];
  assign out_side  = side_r[QUO_BITS];
endmodule

### src/triangle_height_at_xz_unit.sv
// Top level of the triangle plane height pipeline.
// Height of a triangle's plane at a query point in XZ. Each input word carries the three
// vertices and the query point's x and z, all signed Q16.16 (the fraction width cancels, so
// the arithmetic is exact for any format). The block forms the XZ determinant and the two
// barycentric cross terms, one exact numerator and a single division truncating toward zero,
// then adds vertex A's y and clamps to 32 bits, raising the saturated flag on a clamp. A
// degenerate triangle (zero determinant) gives hit low and a height of zero. One word is
// taken every clock cycle unless the output stalls; a result passes through eight arithmetic
// stages, an input register and 34 quotient stages in the divider (one bit per stage), and
// the output register. The whole pipeline, input included, holds as one while a result
// waits at a stalled output, so bubbles inside it are not squeezed out during a stall.
module triangle_height_at_xz_unit import thxz_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, point_x, point_z.
  input  logic [351:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: height.
  output logic [31:0]  out_tdata,
  // Fields from bit 0: hit, saturated.
  output logic [1:0]   out_tuser
);
  `include "triangle_height_at_xz_unit_defines.svh"

  localparam int QUO_BITS = QUO_W;
  localparam int HSUM_W = QUO_BITS + 2;

  logic en;
  // Everything advances together whenever the output register is free or being emptied.
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, px, pz;
  assign ax = in_tdata[31:0];
  assign ay = in_tdata[63:32];
  assign az = in_tdata[95:64];
  assign bx = in_tdata[127:96];
  assign by = in_tdata[159:128];
  assign bz = in_tdata[191:160];
  assign cx = in_tdata[223:192];
  assign cy = in_tdata[255:224];
  assign cz = in_tdata[287:256];
  assign px = in_tdata[319:288];
  assign pz = in_tdata[351:320];

  // Stage 1: edge vectors relative to vertex A, exact in 33 bits.
  logic                      s1_v_r;
  logic signed [DIFF_W-1:0]  s1_bax_r, s1_bay_r, s1_baz_r, s1_cax_r, s1_cay_r, s1_caz_r;
  logic signed [DIFF_W-1:0]  s1_pax_r, s1_paz_r;
  logic [COORD_W-1:0]        s1_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bax_r <= {bx[31], bx} - {ax[31], ax};
      s1_bay_r <= {by[31], by} - {ay[31], ay};
      s1_baz_r <= {bz[31], bz} - {az[31], az};
      s1_cax_r <= {cx[31], cx} - {ax[31], ax};
      s1_cay_r <= {cy[31], cy} - {ay[31], ay};
      s1_caz_r <= {cz[31], cz} - {az[31], az};
      s1_pax_r <= {px[31], px} - {ax[31], ax};
      s1_paz_r <= {pz[31], pz} - {az[31], az};
      s1_ay_r  <= ay;
    end
  end

  // Stage 2: the six cross products.
  logic                      s2_v_r;
  logic signed [PROD_W-1:0]  s2_p0_r, s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r, s2_p5_r;
  logic signed [DIFF_W-1:0]  s2_bay_r, s2_cay_r;
  logic [COORD_W-1:0]        s2_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p0_r  <= s1_bax_r * s1_caz_r;
      s2_p1_r  <= s1_cax_r * s1_baz_r;
      s2_p2_r  <= s1_pax_r * s1_caz_r;
      s2_p3_r  <= s1_cax_r * s1_paz_r;
      s2_p4_r  <= s1_bax_r * s1_paz_r;
      s2_p5_r  <= s1_pax_r * s1_baz_r;
      s2_bay_r <= s1_bay_r;
      s2_cay_r <= s1_cay_r;
      s2_ay_r  <= s1_ay_r;
    end
  end

  // Stage 3: determinant and the two barycentric cross terms.
  logic                     s3_v_r;
  logic signed [DET_W-1:0]  s3_det_r, s3_d1_r, s3_d2_r;
  logic signed [DIFF_W-1:0] s3_bay_r, s3_cay_r;
  logic [COORD_W-1:0]       s3_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_det_r <= {s2_p0_r[PROD_W-1], s2_p0_r} - {s2_p1_r[PROD_W-1], s2_p1_r};
      s3_d1_r  <= {s2_p2_r[PROD_W-1], s2_p2_r} - {s2_p3_r[PROD_W-1], s2_p3_r};
      s3_d2_r  <= {s2_p4_r[PROD_W-1], s2_p4_r} - {s2_p5_r[PROD_W-1], s2_p5_r};
      s3_bay_r <= s2_bay_r;
      s3_cay_r <= s2_cay_r;
      s3_ay_r  <= s2_ay_r;
    end
  end

  // Stage 4: signs and magnitudes, so the wide products can be split unsigned.
  logic               s4_v_r;
  logic [DET_W-1:0]   s4_det_m_r, s4_d1_m_r, s4_d2_m_r;
  logic [DIFF_W-1:0]  s4_bay_m_r, s4_cay_m_r;
  logic               s4_det_n_r, s4_s1_r, s4_s2_r, s4_hit_r;
  logic [COORD_W-1:0] s4_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_det_m_r <= s3_det_r[DET_W-1] ? -s3_det_r : s3_det_r;
      s4_d1_m_r  <= s3_d1_r[DET_W-1] ? -s3_d1_r : s3_d1_r;
      s4_d2_m_r  <= s3_d2_r[DET_W-1] ? -s3_d2_r : s3_d2_r;
      s4_bay_m_r <= s3_bay_r[DIFF_W-1] ? -s3_bay_r : s3_bay_r;
      s4_cay_m_r <= s3_cay_r[DIFF_W-1] ? -s3_cay_r : s3_cay_r;
      s4_det_n_r <= s3_det_r[DET_W-1];
      s4_s1_r    <= s3_d1_r[DET_W-1] ^ s3_bay_r[DIFF_W-1];
      s4_s2_r    <= s3_d2_r[DET_W-1] ^ s3_cay_r[DIFF_W-1];
      s4_hit_r   <= s3_det_r != '0;
      s4_ay_r    <= s3_ay_r;
    end
  end

  // Stage 5: partial products, each cross term split into a low 34-bit and a high 33-bit half.
  localparam int LO_W = 34;
  localparam int HI_W = DET_W - LO_W;
  localparam int PL_W = LO_W + DIFF_W;
  localparam int PH_W = HI_W + DIFF_W;
  localparam int MAG_W = PH_W + LO_W;

  logic               s5_v_r;
  logic [PL_W-1:0]    s5_l1_r, s5_l2_r;
  logic [PH_W-1:0]    s5_h1_r, s5_h2_r;
  logic [DET_W-1:0]   s5_det_m_r;
  logic               s5_det_n_r, s5_s1_r, s5_s2_r, s5_hit_r;
  logic [COORD_W-1:0] s5_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_l1_r    <= s4_d1_m_r[LO_W-1:0] * s4_bay_m_r;
      s5_h1_r    <= s4_d1_m_r[DET_W-1:LO_W] * s4_bay_m_r;
      s5_l2_r    <= s4_d2_m_r[LO_W-1:0] * s4_cay_m_r;
      s5_h2_r    <= s4_d2_m_r[DET_W-1:LO_W] * s4_cay_m_r;
      s5_det_m_r <= s4_det_m_r;
      s5_det_n_r <= s4_det_n_r;
      s5_s1_r    <= s4_s1_r;
      s5_s2_r    <= s4_s2_r;
      s5_hit_r   <= s4_hit_r;
      s5_ay_r    <= s4_ay_r;
    end
  end

  // Stage 6: recombine the halves into the two product magnitudes.
  logic               s6_v_r;
  logic [MAG_W-1:0]   s6_m1_r, s6_m2_r;
  logic [DET_W-1:0]   s6_det_m_r;
  logic               s6_det_n_r, s6_s1_r, s6_s2_r, s6_hit_r;
  logic [COORD_W-1:0] s6_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_m1_r    <= {s5_h1_r, {LO_W{1'b0}}} + {{(MAG_W-PL_W){1'b0}}, s5_l1_r};
      s6_m2_r    <= {s5_h2_r, {LO_W{1'b0}}} + {{(MAG_W-PL_W){1'b0}}, s5_l2_r};
      s6_det_m_r <= s5_det_m_r;
      s6_det_n_r <= s5_det_n_r;
      s6_s1_r    <= s5_s1_r;
      s6_s2_r    <= s5_s2_r;
      s6_hit_r   <= s5_hit_r;
      s6_ay_r    <= s5_ay_r;
    end
  end

  // Stage 7: the signed numerator.
  logic [NUM_W-1:0] t1, t2;
  assign t1 = {{(NUM_W-MAG_W){1'b0}}, s6_m1_r};
  assign t2 = {{(NUM_W-MAG_W){1'b0}}, s6_m2_r};

  logic               s7_v_r;
  logic [NUM_W-1:0]   s7_num_r;
  logic [DET_W-1:0]   s7_det_m_r;
  logic               s7_det_n_r, s7_hit_r;
  logic [COORD_W-1:0] s7_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_num_r   <= (s6_s1_r ? -t1 : t1) + (s6_s2_r ? -t2 : t2);
      s7_det_m_r <= s6_det_m_r;
      s7_det_n_r <= s6_det_n_r;
      s7_hit_r   <= s6_hit_r;
      s7_ay_r    <= s6_ay_r;
    end
  end

  // Stage 8: numerator magnitude and the quotient sign. A quotient of 2^34 or more
  // always saturates, so only its low 34 bits are ever produced.
  logic               s8_v_r;
  logic [NUM_W-1:0]   s8_num_m_r;
  logic [DET_W-1:0]   s8_det_m_r;
  logic               s8_neg_r, s8_hit_r;
  logic [COORD_W-1:0] s8_ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_num_m_r <= s7_num_r[NUM_W-1] ? -s7_num_r : s7_num_r;
      s8_neg_r   <= s7_num_r[NUM_W-1] ^ s7_det_n_r;
      s8_det_m_r <= s7_det_m_r;
      s8_hit_r   <= s7_hit_r;
      s8_ay_r    <= s7_ay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  logic [DET_W-1:0] rem0;
  side_t            div_side_in, div_side_out;
  logic             div_valid;
  logic [QUO_BITS-1:0] div_quo;

  assign rem0             = s8_num_m_r[NUM_W-1 -: DET_W];
  assign div_side_in.a_y  = s8_ay_r;
  assign div_side_in.neg  = s8_neg_r;
  assign div_side_in.ovf  = s8_num_m_r[NUM_W-1:NUM_W-DET_W] >= s8_det_m_r;
  assign div_side_in.hit  = s8_hit_r;

  thxz_div #(
    .DEN_BITS (DET_W),
    .QUO_BITS (QUO_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s8_v_r),
    .in_rem    (rem0),
    .in_den    (s8_det_m_r),
    .in_low    (s8_num_m_r[QUO_BITS-1:0]),
    .in_side   (div_side_in),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side_out)
  );

  // Output stage: apply the sign, add vertex A's y and clamp.
  logic [HSUM_W-1:0] q_ext, q_sgn, h_sum;
  logic              h_hi, h_lo;
  logic [31:0]       height_nxt;
  logic              sat_nxt;

  assign q_ext = {2'b00, div_quo};
  assign q_sgn = div_side_out.neg ? -q_ext : q_ext;
  assign h_sum = q_sgn + {{(HSUM_W-COORD_W){div_side_out.a_y[COORD_W-1]}}, div_side_out.a_y};
  // Out of range when the bits above the sign do not all copy it.
  assign h_hi  = !h_sum[HSUM_W-1] && (h_sum[HSUM_W-2:COORD_W-1] != '0);
  assign h_lo  = h_sum[HSUM_W-1] && (h_sum[HSUM_W-2:COORD_W-1] != '1);

  always_comb begin
    height_nxt = h_sum[COORD_W-1:0];
    sat_nxt    = 1'b0;
    if (!div_side_out.hit) begin
      height_nxt = '0;
    end else if (div_side_out.ovf) begin
      height_nxt = div_side_out.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat_nxt    = 1'b1;
    end else if (h_hi) begin
      height_nxt = 32'h7FFF_FFFF;
      sat_nxt    = 1'b1;
    end else if (h_lo) begin
      height_nxt = 32'h8000_0000;
      sat_nxt    = 1'b1;
    end
  end

  logic        out_v_r;
  logic [31:0] out_height_r;
  logic        out_hit_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_height_r <= height_nxt;
      out_hit_r    <= div_side_out.hit;
      out_sat_r    <= sat_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_height_r;
  assign out_tuser  = {out_sat_r, out_hit_r};

  // A miss always reports a zero height and no clamp.
  `THXZ_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tuser[0],
    out_tdata == '0 && !out_tuser[1], "miss result carries a height or a clamp")
  // A clamped height sits at one of the two range limits.
  `THXZ_ASSERT_IMP(a_sat_limit, out_tvalid && out_tuser[1],
    out_tdata == 32'h7FFF_FFFF || out_tdata == 32'h8000_0000, "clamped height off limit")
  // While the pipeline holds, the stage 1, stage 8 and divider output valids may not change.
  `THXZ_ASSERT_NXT(a_hold, !in_tready,
    $stable(s1_v_r) && $stable(s8_v_r) && $stable(div_valid), "stage moved while stalled")
endmodule

### dv/testbench.sv
// Self-checking testbench for the triangle plane height pipeline.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic signed [31:0] pz;
    logic signed [31:0] px;
    logic signed [31:0] cz;
    logic signed [31:0] cy;
    logic signed [31:0] cx;
    logic signed [31:0] bz;
    logic signed [31:0] by;
    logic signed [31:0] bx;
    logic signed [31:0] az;
    logic signed [31:0] ay;
    logic signed [31:0] ax;
  } query_t;

  typedef struct packed {
    logic        saturated;
    logic        hit;
    logic [31:0] height;
  } height_t;

  localparam int HOLD_OFF_LEN = 300;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [351:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;

  query_t  pending_queries[$];
  height_t expected_heights[$];
  int      errors = 0;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_cycles;
  bit      hold_off_req;
  bit      in_taken;

  triangle_height_at_xz_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Plane height at the query point. Every intermediate is held exactly in wide signed
  // vectors, so the only rounding is the truncating division, as the block performs it.
  function automatic height_t plane_height(query_t q);
    logic signed [127:0] bax, bay, baz, cax, cay, caz, pax, paz;
    logic signed [127:0] det, d1, d2, num, quo, h;
    height_t r;
    bax = 128'(q.bx) - 128'(q.ax);
    bay = 128'(q.by) - 128'(q.ay);
    baz = 128'(q.bz) - 128'(q.az);
    cax = 128'(q.cx) - 128'(q.ax);
    cay = 128'(q.cy) - 128'(q.ay);
    caz = 128'(q.cz) - 128'(q.az);
    pax = 128'(q.px) - 128'(q.ax);
    paz = 128'(q.pz) - 128'(q.az);
    det = bax * caz - cax * baz;
    r = '0;
    if (det == 0) return r;
    d1 = pax * caz - cax * paz;
    d2 = bax * paz - pax * baz;
    num = d1 * bay + d2 * cay;
    // SystemVerilog signed division truncates toward zero.
    quo = num / det;
    h = 128'(q.ay) + quo;
    r.hit = 1'b1;
    if (h > 128'sd2147483647) begin
      r.height = 32'h7FFF_FFFF;
      r.saturated = 1'b1;
    end else if (h < -128'sd2147483648) begin
      r.height = 32'h8000_0000;
      r.saturated = 1'b1;
    end else begin
      r.height = h[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    // Mostly small coordinates so that typical triangles stay in range, with some full width.
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 4;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.ax = rand_coord(); q.ay = rand_coord(); q.az = rand_coord();
    q.bx = rand_coord(); q.by = rand_coord(); q.bz = rand_coord();
    q.cx = rand_coord(); q.cy = rand_coord(); q.cz = rand_coord();
    q.px = rand_coord(); q.pz = rand_coord();
    // Now and then degenerate the triangle in XZ (collinear, repeated vertices) or query at A.
    case ($urandom_range(0, 9))
      0: begin q.bx = q.ax; q.bz = q.az; end
      1: begin q.cx = q.bx; q.cz = q.bz; end
      2: begin
        q.cx = q.ax + 2 * (q.bx - q.ax);
        q.cz = q.az + 2 * (q.bz - q.az);
      end
      3: begin q.px = q.ax; q.pz = q.az; end
      default: ;
    endcase
    return q;
  endfunction

  // Driver: inputs change on the falling edge; a word that was offered stays until accepted.
  // Acceptance is taken from the rising edge, where the queue is also popped.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (pending_queries.size() > 0 &&
                 !(send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_queries[0];
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver readiness: a long hold-off when asked, otherwise a random stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready      <= 1'b0;
      hold_off_cycles <= 0;
    end else if (hold_off_req && hold_off_cycles < HOLD_OFF_LEN) begin
      hold_off_cycles <= hold_off_cycles + 1;
      out_tready      <= 1'b0;
    end else begin
      out_tready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Expected results are queued as each word is accepted.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_heights.push_back(plane_height(query_t'(in_tdata)));
      void'(pending_queries.pop_front());
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    height_t exp_h;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_heights.size() == 0) begin
        $display("%0t: unexpected word height=%h hit=%b sat=%b", $time,
                 out_tdata, out_tuser[0], out_tuser[1]);
        errors++;
      end else begin
        exp_h = expected_heights.pop_front();
        if (out_tdata !== exp_h.height) begin
          $display("%0t: height expected %h actual %h", $time, exp_h.height, out_tdata);
          errors++;
        end
        if (out_tuser[0] !== exp_h.hit) begin
          $display("%0t: hit expected %b actual %b", $time, exp_h.hit, out_tuser[0]);
          errors++;
        end
        if (out_tuser[1] !== exp_h.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_h.saturated,
                   out_tuser[1]);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_queries.size() > 0 || in_tvalid || expected_heights.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    query_t q;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: unit triangle, degenerate cases, extremes and saturation both ways.
    q = '0; q.bx = 32'h0001_0000; q.cz = 32'h0001_0000; q.by = 32'h0002_0000;
    q.px = 32'h0000_8000; q.pz = 32'h0000_4000; pending_queries.push_back(q);
    q = '0; pending_queries.push_back(q);
    q = '1; pending_queries.push_back(q);
    q = '0; q.bx = 32'h0001_0000; q.cx = 32'h0002_0000; pending_queries.push_back(q);
    // Largest triangle with extreme heights.
    q = '0;
    q.ax = 32'h8000_0000; q.az = 32'h8000_0000; q.ay = 32'h8000_0000;
    q.bx = 32'h7FFF_FFFF; q.bz = 32'h8000_0000; q.by = 32'h7FFF_FFFF;
    q.cx = 32'h8000_0000; q.cz = 32'h7FFF_FFFF; q.cy = 32'h7FFF_FFFF;
    q.px = 32'h7FFF_FFFF; q.pz = 32'h7FFF_FFFF; pending_queries.push_back(q);
    q.by = 32'h8000_0000; q.cy = 32'h8000_0000; q.ay = 32'h7FFF_FFFF;
    pending_queries.push_back(q);
    // Steep thin triangle sampled far away: saturates upwards, downwards, then upwards again.
    q = '0; q.bx = 32'd1; q.cz = 32'd1; q.by = 32'h7FFF_FFFF;
    q.px = 32'h7FFF_FFFF; pending_queries.push_back(q);
    q.by = 32'h8000_0000; pending_queries.push_back(q);
    q.px = 32'h8000_0000; pending_queries.push_back(q);
    // Negative then positive fractional quotient, both truncating toward zero.
    q = '0; q.bx = 32'd3; q.cz = 32'd3; q.by = 32'd1; q.px = 32'hFFFF_FFFF;
    pending_queries.push_back(q);
    q.px = 32'd1; pending_queries.push_back(q);
    for (int i = 0; i < 8; i++) pending_queries.push_back(rand_query());
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 85 : (phase == 3) ? 34 : 0;
      recv_stall_pct = (phase == 2) ? 85 : (phase == 3) ? 34 : 0;
      for (int i = 0; i < 230; i++) pending_queries.push_back(rand_query());
      // Mixed stretches without idling inside each phase.
      repeat ($urandom_range(50, 150)) @(posedge clk);
      send_idle_pct = 0; recv_stall_pct = 0;
      repeat ($urandom_range(20, 60)) @(posedge clk);
      send_idle_pct  = (phase == 1) ? 85 : (phase == 3) ? 34 : 0;
      recv_stall_pct = (phase == 2) ? 85 : (phase == 3) ? 34 : 0;
      wait_drained();
    end

    // Back-pressure: the receiver holds off while the sender keeps offering words.
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 200; i++) pending_queries.push_back(rand_query());
    @(negedge clk);
    hold_off_req = 1'b1;
    wait_drained();

    repeat (60) @(posedge clk);
    if (errors == 0 && expected_heights.size() == 0) begin
      $display("triangle_height_at_xz_unit: match");
    end else begin
      $display("triangle_height_at_xz_unit: mismatch");
    end
    $finish;
  end

  // Watchdog for a stuck pipeline.
  initial begin
    #(2_000_000);
    $display("triangle_height_at_xz_unit: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/thxz_pkg.sv
src/thxz_div.sv
src/triangle_height_at_xz_unit.sv
dv/testbench.sv
